// ----- rtl/brlp_pkg.sv -----
package brlp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_REPEAT = 2'd0;
  localparam logic [1:0] CFG_NEXT_REPEAT  = 2'd1;
  localparam logic [1:0] CFG_LONG_PRESS   = 2'd2;

  // Register reset values
  localparam logic [7:0] FIRST_REPEAT_RST = 8'd4;
  localparam logic [7:0] NEXT_REPEAT_RST  = 8'd1;
  localparam logic [7:0] LONG_PRESS_RST   = 8'd16;

  // Raw button byte bit positions
  localparam int RAW_LEFT    = 0;
  localparam int RAW_CONFIRM = 3;
  localparam int RAW_RIGHT   = 4;

  // Packed held-button layout
  localparam int HB_LEFT    = 0;
  localparam int HB_CONFIRM = 1;
  localparam int HB_RIGHT   = 2;
  localparam logic [2:0] HB_ALL     = 3'b111;
  localparam logic [2:0] HB_LR_MASK = 3'b101;

  typedef enum logic [2:0] {
    NAV_NONE          = 3'd0,
    NAV_LEFT          = 3'd1,
    NAV_RIGHT         = 3'd2,
    NAV_CONFIRM_LEFT  = 3'd3,
    NAV_CONFIRM_RIGHT = 3'd4
  } nav_event_t;

  typedef enum logic [1:0] {
    CONF_NONE  = 2'd0,
    CONF_SHORT = 2'd1,
    CONF_LONG  = 2'd2
  } confirm_event_t;

endpackage

// ----- rtl/button_repeat_long_press.sv -----
// Key autorepeat and long-press detector.
// Accepted input is held in the sample register, then in the result register.
// Throughput: one item per cycle unless out_tready stalls a result, set by the
// state update between the two registers; an empty sample register takes an
// item while a result waits. Reset (rst_n low, synchronous) clears held/previous
// buttons and counters and loads the default repeat and long-press counts.
module button_repeat_long_press (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] raw_buttons
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] nav_event, [4:3] confirm_event, [7:5] zero
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import brlp_pkg::*;

  // configuration registers
  logic [7:0] first_repeat_r, next_repeat_r, long_press_r;

  // sample stage
  logic       s1_valid_r;
  logic [2:0] s1_btn_r;     // packed: left, confirm, right

  // detector state
  logic [2:0] held_r, prev_r;
  logic [7:0] repeat_r, long_r;

  // result stage
  logic           out_valid_r;
  nav_event_t     nav_r;
  confirm_event_t conf_r;

  // next-state / datapath
  logic [2:0]     held_nxt;
  logic [2:0]     lr_diff;
  logic           fire;
  logic [7:0]     repeat_nxt, long_nxt, long_a, spent;
  nav_event_t     nav_nxt;
  confirm_event_t conf_nxt;
  logic           adv;      // sample stage moves into result stage
  logic           in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_repeat_r <= FIRST_REPEAT_RST;
      next_repeat_r  <= NEXT_REPEAT_RST;
      long_press_r   <= LONG_PRESS_RST;
    end else if (cfg_valid) begin
      // index beyond the register list is dropped
      unique case (cfg_index)
        CFG_FIRST_REPEAT: first_repeat_r <= cfg_data;
        CFG_NEXT_REPEAT:  next_repeat_r  <= cfg_data;
        CFG_LONG_PRESS:   long_press_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: result register drains or is empty -> sample stage advances.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_btn_r <= {in_tdata[RAW_RIGHT], in_tdata[RAW_CONFIRM], in_tdata[RAW_LEFT]};
    end
  end

  // Per-tick update
  always_comb begin
    // all three down: glitch sample, keep held state
    held_nxt = (s1_btn_r == HB_ALL) ? held_r : s1_btn_r;
    lr_diff  = (held_nxt ^ prev_r) & HB_LR_MASK;
    fire     = (lr_diff != 3'b000) || (repeat_r == 8'd0);
    spent    = long_press_r + 8'd1;  // wraps at 255
    nav_nxt  = NAV_NONE;
    long_a   = long_r;

    // navigation and autorepeat
    if (fire) begin
      if (held_nxt[HB_LEFT]) begin
        nav_nxt = held_nxt[HB_CONFIRM] ? NAV_CONFIRM_LEFT : NAV_LEFT;
      end else if (held_nxt[HB_RIGHT]) begin
        nav_nxt = held_nxt[HB_CONFIRM] ? NAV_CONFIRM_RIGHT : NAV_RIGHT;
      end
      // confirm chord cancels the pending long press
      if (held_nxt[HB_CONFIRM] && (held_nxt[HB_LEFT] || held_nxt[HB_RIGHT])) begin
        long_a = spent;
      end
      repeat_nxt = (lr_diff != 3'b000) ? first_repeat_r : next_repeat_r;
    end else if ((held_nxt & HB_LR_MASK) != 3'b000) begin
      repeat_nxt = repeat_r - 8'd1;  // nonzero here
    end else begin
      repeat_nxt = 8'd0;
    end

    // confirm short / long
    conf_nxt = CONF_NONE;
    priority if (long_a == long_press_r) begin
      long_nxt = long_a + 8'd1;
      conf_nxt = CONF_LONG;
    end else if (!held_nxt[HB_CONFIRM] && prev_r[HB_CONFIRM]) begin
      long_nxt = long_a;
      if (long_a < long_press_r) conf_nxt = CONF_SHORT;
    end else if (held_nxt[HB_CONFIRM] && prev_r[HB_CONFIRM]) begin
      long_nxt = (long_a < long_press_r) ? long_a + 8'd1 : long_a;
    end else begin
      long_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 3'b000;
      prev_r   <= 3'b000;
      repeat_r <= 8'd0;
      long_r   <= 8'd0;
    end else if (adv) begin
      held_r   <= held_nxt;
      prev_r   <= held_nxt;
      repeat_r <= repeat_nxt;
      long_r   <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nav_r  <= nav_nxt;
      conf_r <= conf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, conf_r, nav_r};

endmodule

// ----- rtl/brlp_checker.sv -----
module brlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import brlp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_nav_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= NAV_CONFIRM_RIGHT)
    else $error("bad nav_event code");

  a_conf_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:3] != 2'd3 && out_tdata[7:5] == 3'd0)
    else $error("bad confirm_event code or padding");

  // a confirm chord cancels the long press in the same tick
  a_chord_no_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == NAV_CONFIRM_LEFT ||
                   out_tdata[2:0] == NAV_CONFIRM_RIGHT) |-> out_tdata[4:3] != CONF_LONG)
    else $error("long press together with confirm chord");

  // an idle result stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

endmodule

bind button_repeat_long_press brlp_checker u_brlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brlp_pkg::*;

  // Index past the last register; a write there must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Raw button byte masks (bit positions from the package).
  localparam logic [7:0] KEY_LEFT    = 8'(1) << RAW_LEFT;
  localparam logic [7:0] KEY_CONFIRM = 8'(1) << RAW_CONFIRM;
  localparam logic [7:0] KEY_RIGHT   = 8'(1) << RAW_RIGHT;
  localparam logic [7:0] KEY_UNUSED  = ~(KEY_LEFT | KEY_CONFIRM | KEY_RIGHT);

  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 8;

  typedef struct packed {
    nav_event_t     nav;
    confirm_event_t conf;
  } scan_result_t;

  // Directed row: raw byte, plus a hand-written expectation where pinned.
  typedef struct packed {
    logic [7:0]     raw;
    logic           pinned;
    nav_event_t     nav;
    confirm_event_t conf;
  } opening_row_t;

  typedef struct packed {
    logic         pinned;
    scan_result_t res;
  } pin_t;

  typedef struct packed {
    logic [7:0] first_rpt;
    logic [7:0] next_rpt;
    logic [7:0] long_hold;
  } setting_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata  = 8'h00;  // [7:0] raw_buttons
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [2:0] nav_event, [4:3] confirm_event, [7:5] zero
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data  = 8'h00;

  button_repeat_long_press i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the detector's registers and counters.
  // Held/previous use the packed layout: bit0 left, bit1 confirm, bit2 right.
  // ---------------------------------------------------------------------------
  logic [7:0] first_ticks, next_ticks, long_ticks;
  logic [2:0] btn_held, btn_prev;
  logic [7:0] rpt_left, hold_cnt;

  scan_result_t pending_events[$];  // expected results, oldest first
  pin_t         pinned_q[$];        // one per item sent, in send order
  int unsigned  fail_count   = 0;
  int unsigned  quiet_cycles = 0;
  logic         rx_free      = 1'b0; // receiver never stalls while set
  logic [15:0]  rx_pat       = 16'hffff;
  logic [5:0]   rx_tick      = 6'd0;
  int           burst_left   = 0;
  logic         tx_steady    = 1'b0;

  // One scan tick: update the private state and return the events it causes.
  function automatic scan_result_t scan_tick(input logic [7:0] raw);
    logic [2:0]   smp;
    logic [2:0]   lr_chg;
    logic [7:0]   spent;
    scan_result_t r;
    smp    = {raw[RAW_RIGHT], raw[RAW_CONFIRM], raw[RAW_LEFT]};
    spent  = long_ticks + 8'd1;  // wraps to 0 at 255
    r.nav  = NAV_NONE;
    r.conf = CONF_NONE;
    // all three down: sample dropped, last held state stays
    if (smp != HB_ALL) btn_held = smp;
    lr_chg = (btn_held ^ btn_prev) & HB_LR_MASK;

    // navigation: fire on a left/right change or when the repeat count ran out
    if (lr_chg != 3'b000 || rpt_left == 8'd0) begin
      if (btn_held[HB_LEFT]) begin
        r.nav = btn_held[HB_CONFIRM] ? NAV_CONFIRM_LEFT : NAV_LEFT;
        if (btn_held[HB_CONFIRM]) hold_cnt = spent;  // chord cancels long press
      end else if (btn_held[HB_RIGHT]) begin
        r.nav = btn_held[HB_CONFIRM] ? NAV_CONFIRM_RIGHT : NAV_RIGHT;
        if (btn_held[HB_CONFIRM]) hold_cnt = spent;
      end
      // idle with a zero count reloads too; cleared again next tick
      rpt_left = (lr_chg != 3'b000) ? first_ticks : next_ticks;
    end else if ((btn_held & HB_LR_MASK) != 3'b000) begin
      rpt_left = rpt_left - 8'd1;
    end else begin
      rpt_left = 8'd0;
    end

    // confirm: long event at the threshold, short event on an early release
    if (hold_cnt == long_ticks) begin
      hold_cnt = hold_cnt + 8'd1;
      r.conf   = CONF_LONG;
    end else if (!btn_held[HB_CONFIRM] && btn_prev[HB_CONFIRM]) begin
      if (hold_cnt < long_ticks) r.conf = CONF_SHORT;
    end else if (btn_held[HB_CONFIRM] && btn_prev[HB_CONFIRM]) begin
      if (hold_cnt < long_ticks) hold_cnt = hold_cnt + 8'd1;
    end else begin
      hold_cnt = 8'd0;
    end

    btn_prev = btn_held;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: config writes, accepted items and results, all seen at the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    scan_result_t got;
    scan_result_t want;
    pin_t         pin;
    if (!rst_n) begin
      first_ticks = FIRST_REPEAT_RST;
      next_ticks  = NEXT_REPEAT_RST;
      long_ticks  = LONG_PRESS_RST;
      btn_held    = 3'b000;
      btn_prev    = 3'b000;
      rpt_left    = 8'd0;
      hold_cnt    = 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_REPEAT: first_ticks = cfg_data;
          CFG_NEXT_REPEAT:  next_ticks  = cfg_data;
          CFG_LONG_PRESS:   long_ticks  = cfg_data;
          default: ;  // out of range, ignored
        endcase
      end

      if (in_tvalid && in_tready) begin
        got = scan_tick(in_tdata);
        pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
        pending_events.push_back(pin.pinned ? pin.res : got);
      end

      if (out_tvalid && out_tready) begin
        if (pending_events.size() == 0) begin
          $error("result with nothing expected: out_tdata=0x%02h", out_tdata);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_tdata[2:0] !== want.nav) begin
            $error("nav_event: expected %0d, got %0d", want.nav, out_tdata[2:0]);
            fail_count++;
          end
          if (out_tdata[4:3] !== want.conf) begin
            $error("confirm_event: expected %0d, got %0d", want.conf, out_tdata[4:3]);
            fail_count++;
          end
          if (out_tdata[7:5] !== 3'b000) begin
            $error("tdata pad: expected 0, got %0d", out_tdata[7:5]);
            fail_count++;
          end
        end
      end

      // watchdog: count cycles with no handshake on any channel
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
          (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: rotating 16-bit ready pattern, reloaded with a random value when rx_tick is zero.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd0)
      rx_pat <= 16'($urandom);
    else
      rx_pat <= {rx_pat[0], rx_pat[15:1]};
    out_tready <= rx_free || rx_pat[0];
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Send one item; opens a new burst (after an optional gap) when one ends.
  task automatic send_scan(input logic [7:0] raw, input pin_t pin);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pinned_q.push_back(pin);
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
  endtask

  // Caller drops cfg_valid after the last write of a group.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop sending, let every result drain, then allow for the pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Opening sequence under reset settings (first 4, next 1, long 16).
  opening_row_t opening [28] = '{
    '{8'h00, 1'b1, NAV_NONE,  CONF_NONE},  // idle after reset
    '{8'h00, 1'b1, NAV_NONE,  CONF_NONE},  // idle, repeat count cleared
    '{8'h01, 1'b1, NAV_LEFT,  CONF_NONE},  // fresh left press
    '{8'h01, 1'b0, NAV_NONE,  CONF_NONE},  // left held: first then next repeat
    '{8'h01, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h01, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h01, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h01, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h19, 1'b0, NAV_NONE,  CONF_NONE},  // all three down: dropped
    '{8'h00, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h10, 1'b1, NAV_RIGHT, CONF_NONE},  // fresh right press
    '{8'h10, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h00, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h08, 1'b0, NAV_NONE,  CONF_NONE},  // short confirm
    '{8'h08, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h00, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h08, 1'b0, NAV_NONE,  CONF_NONE},  // confirm chord with left
    '{8'h09, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h09, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h08, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h00, 1'b0, NAV_NONE,  CONF_NONE},  // release after chord: no short
    '{8'h18, 1'b0, NAV_NONE,  CONF_NONE},  // chord with right, short on release
    '{8'h00, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'he6, 1'b0, NAV_NONE,  CONF_NONE},  // unused bits only
    '{8'hff, 1'b0, NAV_NONE,  CONF_NONE},  // every bit set: dropped
    '{8'h11, 1'b0, NAV_NONE,  CONF_NONE},  // left and right together
    '{8'h11, 1'b0, NAV_NONE,  CONF_NONE},
    '{8'h00, 1'b0, NAV_NONE,  CONF_NONE}
  };

  // Register settings per random phase: extremes first, random at the end.
  setting_t plan [PHASES] = '{
    '{8'd0,   8'd0,   8'd1},
    '{8'd255, 8'd255, 8'd254},
    '{8'd2,   8'd1,   8'd3},
    '{8'd0,   8'd1,   8'd0},    // long press threshold at zero
    '{8'd1,   8'd0,   8'd255},  // threshold at 255: spent marker wraps
    '{8'd3,   8'd2,   8'd8},
    '{8'd0,   8'd0,   8'd1},
    '{8'd0,   8'd0,   8'd1}
  };

  initial begin : driver
    setting_t   st;
    int         n_items, sent, len, hold_max;
    logic [7:0] base, raw;
    logic       noise;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i])
      send_scan(opening[i].raw, '{opening[i].pinned, '{opening[i].nav, opening[i].conf}});

    for (int p = 6; p < PHASES; p++)
      plan[p] = '{8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                  8'($urandom_range(1, 20))};

    for (int p = 0; p < PHASES; p++) begin
      st = plan[p];
      // block must be idle for register writes
      settle();
      write_reg(CFG_SPARE, 8'($urandom));
      write_reg(CFG_FIRST_REPEAT, st.first_rpt);
      write_reg(CFG_NEXT_REPEAT, st.next_rpt);
      write_reg(CFG_LONG_PRESS, st.long_hold);
      cfg_valid <= 1'b0;

      // some phases run with no idling on either side
      tx_steady = (p % 3 == 2);
      rx_free  <= (p % 3 == 2);

      // long thresholds need holds past the threshold to reach the long event
      hold_max = (st.long_hold > 8'd40) ? int'(st.long_hold) + 6 : 40;
      n_items  = (st.long_hold > 8'd40) ? int'(st.long_hold) + 60 : 70;
      sent     = 0;
      while (sent < n_items) begin
        noise = 1'b0;
        case ($urandom_range(0, 9))
          0: base = 8'h00;
          1: base = KEY_LEFT;
          2: base = KEY_RIGHT;
          3: base = KEY_CONFIRM;
          4: base = KEY_CONFIRM | KEY_LEFT;
          5: base = KEY_CONFIRM | KEY_RIGHT;
          6: base = KEY_LEFT | KEY_RIGHT;
          7: base = KEY_LEFT | KEY_CONFIRM | KEY_RIGHT;
          default: begin
            base  = 8'h00;
            noise = 1'b1;
          end
        endcase
        if (noise)
          len = $urandom_range(1, 8);
        else if ((base & KEY_CONFIRM) != 0 && st.long_hold > 8'd40 && $urandom_range(0, 1))
          len = int'(st.long_hold) + $urandom_range(0, 6);
        else
          len = $urandom_range(1, hold_max);
        // a hold is cut short once the phase has its share of items
        for (int k = 0; k < len && sent < n_items; k++) begin
          // unused bits toggle freely under a held pattern
          raw = noise ? 8'($urandom) : (base | (8'($urandom) & KEY_UNUSED));
          send_scan(raw, '0);
          sent++;
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
